/* hdl/cftf_pkg.sv */
// Package for the clause falsifier table filter.
// Holds request and status codes, sizes and the FSM state type; no dependencies.
`default_nettype none
package cftf_pkg;
    localparam int MAX_GRAPHS_DEF  = 65536;
    localparam int MAX_CLASSES_DEF = 8192;
    localparam int EDGE_BITS_DEF   = 32;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_CLAUSE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ELIM      = 3'd1,
        ST_FULL      = 3'd2,
        ST_RANGE     = 3'd3,
        ST_REFUSED   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_READ_RD,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_SCAN_LAST,
        S_SCAN_SWAP,
        S_SCAN_CNT,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

/* hdl/clause_falsifier_table_filter.sv */
// Clause falsifier table filter, top level: sequencer around the table and counters.
// Depends on cftf_pkg, cftf_table and cftf_counts.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one request item; m_tvalid/m_tready/m_tdata
//   return one result item per request. cfg_valid/cfg_ready/cfg_data write the
//   edge_count register (low 6 bits); write it only while no request is in flight.
// Steps from the accepting edge to the edge that raises m_tvalid: load reads the
//   class count, then writes entry and count; read fetches the entry; refused,
//   full, out-of-range, unknown or empty clause go straight to the result. A
//   scan compares each entry; a removed one adds a read of last entry and class
//   count, two swap writes and a slot reread; the table has a single read port.
// Throughput: one request at a time; the next item is taken in the cycle after
//   the result moves into the output register.
// Reset: live count, error flag and control registers reset at once, edge_count
//   to 32; then a clearing pass zeroes the MAX_CLASSES class counters in turn,
//   during which no item is accepted (configuration writes are still taken).
// A stalled receiver holds the result in the output register; one more request
//   is accepted and processed, and its result waits until the register frees.
`default_nettype none
module clause_falsifier_table_filter
    import cftf_pkg::*;
#(
    parameter int MAX_GRAPHS  = MAX_GRAPHS_DEF,
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int EDGE_BITS   = EDGE_BITS_DEF
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_data,   // [5:0] edge_count
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [1:0] req_type, [33:2] graph_mask, [46:34] class_id, [78:47] pos_mask,
    // [110:79] neg_mask, [126:111] entry_index, [127] zero
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [2:0] status, [19:3] removed_count, [36:20] live_entries,
    // [49:37] eliminated_class, [81:50] read_mask, [94:82] read_class, [95] zero
    output logic [95:0]       m_tdata
);
    localparam int GA = $clog2(MAX_GRAPHS);
    localparam int CA = $clog2(MAX_CLASSES);
    localparam int LW = GA + 1;
    localparam int MW = (EDGE_BITS < 32) ? EDGE_BITS : 32;
    localparam int TW = MW + CA;

    // input fields
    logic [1:0]  f_req;
    logic [31:0] f_gmask, f_pos, f_neg;
    logic [12:0] f_class;
    logic [15:0] f_idx;
    assign f_req   = s_tdata[1:0];
    assign f_gmask = s_tdata[33:2];
    assign f_class = s_tdata[46:34];
    assign f_pos   = s_tdata[78:47];
    assign f_neg   = s_tdata[110:79];
    assign f_idx   = s_tdata[126:111];

    state_t state_reg, state_next;
    logic [5:0]    ecount_reg;
    logic [LW-1:0] live_reg, live_next;
    logic          err_reg, err_next;
    logic [LW-1:0] i_reg, i_next;
    logic [MW-1:0] pos_reg, pos_next, neg_reg, neg_next, ones_reg, ones_next;
    logic [MW-1:0] cur_m_reg, cur_m_next;
    logic [CA-1:0] cur_c_reg, cur_c_next;
    logic [CA-1:0] ld_c_reg, ld_c_next;
    logic [MW-1:0] ld_m_reg, ld_m_next;
    logic [16:0]   removed_reg, removed_next;
    logic [2:0]    status_reg, status_next;
    logic [12:0]   elim_reg, elim_next;
    logic [31:0]   rmask_reg, rmask_next;
    logic [12:0]   rclass_reg, rclass_next;
    logic [CA-1:0] clr_reg, clr_next;

    // memories
    logic          t_we;
    logic [GA-1:0] t_waddr, t_raddr;
    logic [TW-1:0] t_wdata, t_rdata;
    logic          c_we;
    logic [CA-1:0] c_waddr, c_raddr;
    logic [16:0]   c_wdata, c_rdata;

    cftf_table #(.AW(GA), .DW(TW)) u_table (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );
    cftf_counts #(.AW(CA), .DW(17)) u_counts (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    logic [MW-1:0] rd_m;
    logic [CA-1:0] rd_c;
    assign rd_m = t_rdata[MW-1:0];
    assign rd_c = t_rdata[TW-1:MW];

    logic [MW-1:0] ones_calc;
    always_comb
    begin
        if (ecount_reg >= 6'(MW))
            ones_calc = '1;
        else
            ones_calc = MW'((64'd1 << ecount_reg) - 64'd1);
    end

    logic [CA-1:0] class_mod;
    assign class_mod = CA'(f_class);

    logic       mvalid_reg;
    logic [95:0] mdata_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);

    logic out_load;
    logic [LW-1:0] last_w;
    assign last_w = live_reg - LW'(1);

    always_comb
    begin
        state_next   = state_reg;
        live_next    = live_reg;
        err_next     = err_reg;
        i_next       = i_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        ones_next    = ones_reg;
        cur_m_next   = cur_m_reg;
        cur_c_next   = cur_c_reg;
        ld_c_next    = ld_c_reg;
        ld_m_next    = ld_m_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        elim_next    = elim_reg;
        rmask_next   = rmask_reg;
        rclass_next  = rclass_reg;
        clr_next     = clr_reg;
        t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = i_reg[GA-1:0];
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = cur_c_reg;
        out_load = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                c_we = 1'b1; c_waddr = clr_reg; c_wdata = '0;
                clr_next = clr_reg + CA'(1);
                if (clr_reg == CA'(MAX_CLASSES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    status_next  = ST_OK;
                    removed_next = '0;
                    elim_next    = '0;
                    rmask_next   = '0;
                    rclass_next  = '0;
                    case (f_req)
                        REQ_LOAD:
                        begin
                            if (live_reg >= LW'(MAX_GRAPHS))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                ld_c_next  = class_mod;
                                ld_m_next  = MW'(f_gmask);
                                c_raddr    = class_mod;
                                state_next = S_LOAD_RD;
                            end
                        end
                        REQ_CLAUSE:
                        begin
                            if (err_reg)
                            begin
                                status_next = ST_REFUSED;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                pos_next   = MW'(f_pos);
                                neg_next   = MW'(f_neg);
                                ones_next  = ones_calc;
                                i_next     = '0;
                                t_raddr    = '0;
                                state_next = (live_reg == '0) ? S_OUT : S_SCAN_EVAL;
                            end
                        end
                        REQ_READ:
                        begin
                            if (32'(f_idx) >= 32'(live_reg) || 32'(f_idx) >= MAX_GRAPHS)
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                t_raddr    = GA'(f_idx);
                                state_next = S_READ_RD;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_LOAD_RD:
            begin
                // hold the count address so the read data survives into S_LOAD_WR
                c_raddr    = ld_c_reg;
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR:
            begin
                t_we = 1'b1; t_waddr = live_reg[GA-1:0]; t_wdata = {ld_c_reg, ld_m_reg};
                c_we = 1'b1; c_waddr = ld_c_reg; c_wdata = c_rdata + 17'd1;
                live_next  = live_reg + LW'(1);
                state_next = S_OUT;
            end
            S_READ_RD:
            begin
                rmask_next  = 32'(rd_m);
                rclass_next = 13'(rd_c);
                state_next  = S_OUT;
            end
            S_SCAN_RD:
            begin
                // memory read of entry i issued last cycle through t_raddr
                state_next = S_SCAN_EVAL;
            end
            S_SCAN_EVAL:
            begin
                cur_m_next = rd_m;
                cur_c_next = rd_c;
                if (((rd_m & pos_reg) == '0) && (((rd_m ^ ones_reg) & neg_reg) == '0))
                begin
                    t_raddr    = last_w[GA-1:0];
                    c_raddr    = rd_c;
                    state_next = S_SCAN_LAST;
                end
                else
                begin
                    i_next  = i_reg + LW'(1);
                    t_raddr = GA'(i_reg + LW'(1));
                    if (i_reg + LW'(1) >= live_reg)
                        state_next = S_OUT;
                    else
                        state_next = S_SCAN_EVAL;
                end
            end
            S_SCAN_LAST:
            begin
                // move the last entry into slot i, dead entry goes to last
                t_we = 1'b1; t_waddr = i_reg[GA-1:0]; t_wdata = t_rdata;
                c_we = 1'b1; c_waddr = cur_c_reg;
                c_wdata = (c_rdata != '0) ? c_rdata - 17'd1 : '0;
                live_next    = last_w;
                removed_next = removed_reg + 17'd1;
                if (c_rdata <= 17'd1)
                begin
                    status_next = ST_ELIM;
                    elim_next   = 13'(cur_c_reg);
                    err_next    = 1'b1;
                    state_next  = S_SCAN_SWAP;
                end
                else
                    state_next = S_SCAN_SWAP;
            end
            S_SCAN_SWAP:
            begin
                t_we = 1'b1; t_waddr = live_reg[GA-1:0]; t_wdata = {cur_c_reg, cur_m_reg};
                t_raddr = i_reg[GA-1:0];
                if (status_reg == ST_ELIM || i_reg >= live_reg)
                    state_next = S_OUT;
                else
                    state_next = S_SCAN_CNT;
            end
            // reread slot i; its new contents arrive in S_SCAN_EVAL
            S_SCAN_CNT: state_next = S_SCAN_EVAL;
            S_OUT:
            begin
                // hold the result until the output register frees
                if (!mvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            live_reg   <= '0;
            err_reg    <= 1'b0;
            ecount_reg <= 6'd32;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
            i_reg      <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            live_reg   <= live_next;
            err_reg    <= err_next;
            clr_reg    <= clr_next;
            i_reg      <= i_next;
            status_reg <= status_next;
            if (cfg_valid && cfg_ready)
                ecount_reg <= cfg_data[5:0];
            if (out_load)
                mvalid_reg <= 1'b1;
            else if (m_tready)
                mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        neg_reg     <= neg_next;
        ones_reg    <= ones_next;
        cur_m_reg   <= cur_m_next;
        cur_c_reg   <= cur_c_next;
        ld_c_reg    <= ld_c_next;
        ld_m_reg    <= ld_m_next;
        removed_reg <= removed_next;
        elim_reg    <= elim_next;
        rmask_reg   <= rmask_next;
        rclass_reg  <= rclass_next;
        if (out_load)
            mdata_reg <= {1'b0, rclass_reg, rmask_reg, elim_reg, 17'(live_reg),
                          removed_reg, status_reg};
    end

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LW'(MAX_GRAPHS))
        else $error("live count beyond table depth");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("error flag dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while busy");
    a_live_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg != $past(live_reg)) |-> ($past(state_reg) == S_LOAD_WR
            || $past(state_reg) == S_SCAN_LAST))
        else $error("live count changed outside load or removal");
endmodule
`default_nettype wire

/* hdl/cftf_table.sv */
// Graph table memory: edge mask and class per entry, one write and one read port.
// Depends on cftf_pkg for nothing but the house import.
`default_nettype none
module cftf_table
    import cftf_pkg::*;
#(
    parameter int AW = 16,
    parameter int DW = 45
)(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/cftf_counts.sv */
// Per-class live counters: one write and one read port, read data registered.
// Depends on cftf_pkg for nothing but the house import.
`default_nettype none
module cftf_counts
    import cftf_pkg::*;
#(
    parameter int AW = 13,
    parameter int DW = 17
)(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
